@@ sv/msr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package msr_pkg;

  // Fixed field widths
  localparam int SAMPLE_W = 20;
  localparam int SUM_W    = 24;
  localparam int CFG_W    = 5;
  localparam int PIX_W    = 8;
  localparam int FRAC_W   = 8;

  // Width that carries an effective count for any supported MAX_SAMPLES (1..64)
  localparam int NUM_W    = 7;

  // Quotient bits worked out one per cycle; the upper bits only decide saturation
  localparam int QUOT_W   = 8;

  localparam int NUM_CH   = 3;

  localparam int MAX_SAMPLES_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [CFG_W-1:0] CFG_RESET    = CFG_W'(1);
  localparam logic [PIX_W-1:0] ALPHA_OPAQUE = '1;
  localparam logic [PIX_W-1:0] CHAN_SAT     = '1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_red;
    logic signed [SAMPLE_W-1:0] sample_green;
    logic signed [SAMPLE_W-1:0] sample_blue;
    logic                       last_of_frame;
  } sample_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_red;
    logic [PIX_W-1:0] pixel_green;
    logic [PIX_W-1:0] pixel_blue;
    logic [PIX_W-1:0] pixel_alpha;
    logic             frame_done;
  } pixel_t;

  // One finished pixel's sums, handed from the accumulator to the divider
  typedef struct packed {
    logic signed [SUM_W-1:0] sum_red;
    logic signed [SUM_W-1:0] sum_green;
    logic signed [SUM_W-1:0] sum_blue;
    logic [NUM_W-1:0]        count;
    logic                    last;
  } job_t;

endpackage

`default_nettype wire

@@ sv/msr_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module msr_front #(
  parameter int MAX_SAMPLES = msr_pkg::MAX_SAMPLES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [msr_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          take,
  input  wire msr_pkg::sample_t              sample,
  output logic                               job_valid,
  output msr_pkg::job_t                      job
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int CMP_W = (CNT_W > msr_pkg::CFG_W) ? CNT_W : msr_pkg::CFG_W;

  logic [msr_pkg::CFG_W-1:0]         sample_count;
  logic [CNT_W-1:0]                  samples_seen;
  logic signed [msr_pkg::SUM_W-1:0]  red_sum, green_sum, blue_sum;
  logic signed [msr_pkg::SUM_W-1:0]  red_sum_next, green_sum_next, blue_sum_next;
  logic [CNT_W-1:0]                  eff_count;
  logic [CNT_W:0]                    seen_inc;
  logic                              complete;

  // Clamp the register into 1..MAX_SAMPLES
  always_comb begin
    if (sample_count == '0) begin
      eff_count = CNT_W'(1);
    end else if (CMP_W'(sample_count) > CMP_W'(MAX_SAMPLES)) begin
      eff_count = CNT_W'(MAX_SAMPLES);
    end else begin
      eff_count = CNT_W'(sample_count);
    end
  end

  assign red_sum_next   = red_sum   + msr_pkg::SUM_W'(sample.sample_red);
  assign green_sum_next = green_sum + msr_pkg::SUM_W'(sample.sample_green);
  assign blue_sum_next  = blue_sum  + msr_pkg::SUM_W'(sample.sample_blue);

  assign seen_inc = {1'b0, samples_seen} + (CNT_W + 1)'(1);
  assign complete = seen_inc >= {1'b0, eff_count};

  assign job_valid     = take && complete;
  assign job.sum_red   = red_sum_next;
  assign job.sum_green = green_sum_next;
  assign job.sum_blue  = blue_sum_next;
  assign job.count     = msr_pkg::NUM_W'(eff_count);
  assign job.last      = sample.last_of_frame;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= msr_pkg::CFG_RESET;
    end else if (cfg_we) begin
      sample_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_seen <= '0;
      red_sum      <= '0;
      green_sum    <= '0;
      blue_sum     <= '0;
    end else if (take) begin
      if (complete) begin
        samples_seen <= '0;
        red_sum      <= '0;
        green_sum    <= '0;
        blue_sum     <= '0;
      end else begin
        samples_seen <= seen_inc[CNT_W-1:0];
        red_sum      <= red_sum_next;
        green_sum    <= green_sum_next;
        blue_sum     <= blue_sum_next;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/msr_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module msr_queue #(
  parameter int DEPTH = msr_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr,
  input  wire msr_pkg::job_t  wr_data,
  input  wire logic           rd,
  output msr_pkg::job_t       rd_data,
  output logic                full,
  output logic                not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  msr_pkg::job_t    mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full      = fill == CNT_W'(DEPTH);
  assign not_empty = fill != '0;
  assign rd_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (wr && !rd) begin
        fill <= fill + CNT_W'(1);
      end else if (rd && !wr) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/msr_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module msr_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           job_ready,
  input  wire msr_pkg::job_t  job,
  output logic                job_take,
  input  wire logic           pop,
  output logic                empty,
  output msr_pkg::pixel_t     pixel
);

  localparam int NUM_W  = msr_pkg::NUM_W;
  localparam int QUOT_W = msr_pkg::QUOT_W;
  localparam int SUM_W  = msr_pkg::SUM_W;
  localparam int FRAC_W = msr_pkg::FRAC_W;
  localparam int NUM_CH = msr_pkg::NUM_CH;
  localparam int STEP_W = $clog2(QUOT_W);
  localparam int Y_W    = SUM_W - FRAC_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]        state;
  logic [STEP_W-1:0] step;
  logic [NUM_W-1:0]  count;
  logic              last;
  logic              zero [NUM_CH];
  logic              sat  [NUM_CH];
  logic [NUM_W-1:0]  rem  [NUM_CH];
  logic [QUOT_W-1:0] quo  [NUM_CH];
  logic              out_valid;

  logic signed [SUM_W-1:0] job_sum   [NUM_CH];
  logic [SUM_W-1:0]        biased    [NUM_CH];
  logic [Y_W-1:0]          scaled    [NUM_CH];
  logic [QUOT_W-1:0]       scaled_hi [NUM_CH];
  logic                    load_zero [NUM_CH];
  logic                    load_sat  [NUM_CH];
  logic [NUM_W:0]          trial     [NUM_CH];
  logic                    fits      [NUM_CH];
  logic [NUM_W-1:0]        rem_next  [NUM_CH];
  logic [QUOT_W-1:0]       chan      [NUM_CH];
  logic                    out_free;

  assign job_sum[0] = job.sum_red;
  assign job_sum[1] = job.sum_green;
  assign job_sum[2] = job.sum_blue;

  // Load: q = floor((sum + 128n) / 256 / n); the top byte decides saturation
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      load_zero[c] = job_sum[c][SUM_W-1] || (job_sum[c] == '0);
      biased[c]    = {1'b0, job_sum[c][SUM_W-2:0]}
                   + SUM_W'({job.count, {(FRAC_W - 1){1'b0}}});
      scaled[c]    = biased[c][SUM_W-1:FRAC_W];
      scaled_hi[c] = scaled[c][Y_W-1:Y_W-QUOT_W];
      load_sat[c]  = scaled_hi[c] >= QUOT_W'(job.count);
    end
  end

  // One restoring-division step per lane
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      trial[c] = {rem[c], quo[c][QUOT_W-1]};
      fits[c]  = trial[c] >= {1'b0, count};
      if (fits[c]) begin
        rem_next[c] = NUM_W'(trial[c] - {1'b0, count});
      end else begin
        rem_next[c] = trial[c][NUM_W-1:0];
      end
      if (zero[c]) begin
        chan[c] = '0;
      end else if (sat[c]) begin
        chan[c] = msr_pkg::CHAN_SAT;
      end else begin
        chan[c] = quo[c];
      end
    end
  end

  assign out_free = !out_valid || pop;
  assign job_take = (state == ST_IDLE) && job_ready;
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if ((state == ST_OUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (job_ready) begin
            state <= ST_DIV;
            step  <= '0;
          end
        end
        ST_DIV: begin
          step <= step + STEP_W'(1);
          if (step == STEP_W'(QUOT_W - 1)) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      count <= job.count;
      last  <= job.last;
      for (int c = 0; c < NUM_CH; c++) begin
        zero[c] <= load_zero[c];
        sat[c]  <= load_sat[c];
        rem[c]  <= scaled_hi[c][NUM_W-1:0];
        quo[c]  <= scaled[c][QUOT_W-1:0];
      end
    end else if (state == ST_DIV) begin
      for (int c = 0; c < NUM_CH; c++) begin
        rem[c] <= rem_next[c];
        quo[c] <= {quo[c][QUOT_W-2:0], fits[c]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_OUT) && out_free) begin
      pixel.pixel_red   <= chan[0];
      pixel.pixel_green <= chan[1];
      pixel.pixel_blue  <= chan[2];
      pixel.pixel_alpha <= msr_pkg::ALPHA_OPAQUE;
      pixel.frame_done  <= last;
    end
  end

endmodule

`default_nettype wire

@@ sv/multisample_resolve_box.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake            Word
// input     push / full          sample : msr_pkg::sample_t (one subsample)
// result    pop / empty          pixel  : msr_pkg::pixel_t  (one RGBA8 pixel)
// config    cfg_we               cfg_data : sample_count, 5 bits
//
// Subsamples go in at one per cycle while the pixel queue has room. Each finished
// pixel then passes through the back end: a load, 8 restoring-division steps
// (one quotient bit per cycle, three channels side by side), then a write to the
// result register. Reset clears the sums, the queue and the result valid flag;
// sample_count returns to 1. A stalled result holds in its register and the queue
// fills behind it; full rises once the queue holds QUEUE_DEPTH pixels.

module multisample_resolve_box #(
  parameter int MAX_SAMPLES = msr_pkg::MAX_SAMPLES_DEF,
  parameter int QUEUE_DEPTH = msr_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [msr_pkg::CFG_W-1:0] cfg_data,
  input  wire logic                      push,
  output logic                           full,
  input  wire msr_pkg::sample_t          sample,
  output logic                           empty,
  input  wire logic                      pop,
  output msr_pkg::pixel_t                pixel
);

  logic          take;
  logic          job_valid;
  msr_pkg::job_t job_in;
  msr_pkg::job_t job_out;
  logic          job_ready;
  logic          job_take;

  // Hold input while the queue is full; the accumulator never stalls otherwise
  assign take = push && !full;

  // Front end: clamp the count, accumulate sums, emit a job per pixel
  msr_front #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .take     (take),
    .sample   (sample),
    .job_valid(job_valid),
    .job      (job_in)
  );

  // Short queue so the accumulator and the divider stall independently
  msr_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (job_valid),
    .wr_data  (job_in),
    .rd       (job_take),
    .rd_data  (job_out),
    .full     (full),
    .not_empty(job_ready)
  );

  // Back end: divide, round half up, clamp and register the pixel
  msr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .job_ready(job_ready),
    .job      (job_out),
    .job_take (job_take),
    .pop      (pop),
    .empty    (empty),
    .pixel    (pixel)
  );

endmodule

`default_nettype wire
